@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds at that edge.
`define RBU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("relative bearing check failed");

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define RBU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("relative bearing check failed");

`endif

@@ rtl/core/rbu_pkg.sv @@
// ----------------------------------------------------------------------------
// rbu_pkg
// Shared widths, constants, the arctangent table and the cell data type.
// ----------------------------------------------------------------------------
package rbu_pkg;

	localparam int POS_W     = 24;            // position field width
	localparam int ANG_W     = 16;            // binary angle width
	localparam int STEPS     = 16;            // CORDIC cells in the chain
	localparam int DIFF_W    = POS_W + 1;     // exact position difference
	localparam int DATA_W    = 64;            // CORDIC x/y datapath
	localparam int GUARD     = 60 - POS_W;    // guard bits below the difference
	localparam int Z_W       = 32;            // angle accumulator, fraction of a turn
	localparam int TABLE_LEN = 24;
	localparam int IDX_W     = 5;             // holds any index below TABLE_LEN
	localparam int LATENCY   = STEPS + 3;     // two front stages, cells, one output stage

	localparam logic [Z_W-1:0] QUARTER_TURN = 32'h4000_0000;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic [Z_W-1:0]           z;
		logic [ANG_W-1:0]         heading;
		logic                     same;
	} cordic_t;

	// atan(2^-i) as a 32-bit fraction of a turn, rounded
	function automatic logic [Z_W-1:0] atan_turn(input logic [IDX_W-1:0] idx);
		logic [Z_W-1:0] val;
		case (idx)
			5'd0:    val = 32'h2000_0000;
			5'd1:    val = 32'h12E4_051E;
			5'd2:    val = 32'h09FB_385B;
			5'd3:    val = 32'h0511_11D4;
			5'd4:    val = 32'h028B_0D43;
			5'd5:    val = 32'h0145_D7E1;
			5'd6:    val = 32'h00A2_F61E;
			5'd7:    val = 32'h0051_7C55;
			5'd8:    val = 32'h0028_BE53;
			5'd9:    val = 32'h0014_5F2F;
			5'd10:   val = 32'h000A_2F98;
			5'd11:   val = 32'h0005_17CC;
			5'd12:   val = 32'h0002_8BE6;
			5'd13:   val = 32'h0001_45F3;
			5'd14:   val = 32'h0000_A2FA;
			5'd15:   val = 32'h0000_517D;
			5'd16:   val = 32'h0000_28BE;
			5'd17:   val = 32'h0000_145F;
			5'd18:   val = 32'h0000_0A30;
			5'd19:   val = 32'h0000_0518;
			5'd20:   val = 32'h0000_028C;
			5'd21:   val = 32'h0000_0146;
			5'd22:   val = 32'h0000_00A3;
			5'd23:   val = 32'h0000_0051;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

@@ rtl/core/rbu_front.sv @@
// ----------------------------------------------------------------------------
// rbu_front
// Position differences, coincidence test and half-plane pre-rotation.
// ----------------------------------------------------------------------------
module rbu_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [rbu_pkg::POS_W-1:0]    focal_x,
	input  logic signed [rbu_pkg::POS_W-1:0]    focal_y,
	input  logic signed [rbu_pkg::ANG_W-1:0]    focal_heading,
	input  logic signed [rbu_pkg::POS_W-1:0]    neighbor_x,
	input  logic signed [rbu_pkg::POS_W-1:0]    neighbor_y,
	output logic                                out_valid,
	output rbu_pkg::cordic_t                    out_data
);

	logic signed [rbu_pkg::DIFF_W-1:0] dx_s1, dy_s1;
	logic [rbu_pkg::ANG_W-1:0]         heading_s1;
	logic                              same_s1;
	logic                              valid_s1, valid_s2;
	rbu_pkg::cordic_t                  data_s2, rot;
	logic signed [rbu_pkg::DATA_W-1:0] sx, sy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: exact differences
	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			dx_s1      <= rbu_pkg::DIFF_W'(neighbor_x) - rbu_pkg::DIFF_W'(focal_x);
			dy_s1      <= rbu_pkg::DIFF_W'(neighbor_y) - rbu_pkg::DIFF_W'(focal_y);
			heading_s1 <= focal_heading;
			same_s1    <= (neighbor_x == focal_x) && (neighbor_y == focal_y);
		end
	end

	// stage 2: scale up by the guard bits, fold the left half plane
	always_comb begin
		sx = {{(rbu_pkg::DATA_W - rbu_pkg::DIFF_W){dx_s1[rbu_pkg::DIFF_W-1]}}, dx_s1}
			<<< rbu_pkg::GUARD;
		sy = {{(rbu_pkg::DATA_W - rbu_pkg::DIFF_W){dy_s1[rbu_pkg::DIFF_W-1]}}, dy_s1}
			<<< rbu_pkg::GUARD;
		rot.heading = heading_s1;
		rot.same    = same_s1;
		if (!dx_s1[rbu_pkg::DIFF_W-1]) begin
			rot.x = sx;
			rot.y = sy;
			rot.z = '0;
		end else if (!dy_s1[rbu_pkg::DIFF_W-1]) begin
			rot.x = sy;
			rot.y = -sx;
			rot.z = rbu_pkg::QUARTER_TURN;
		end else begin
			rot.x = -sy;
			rot.y = sx;
			rot.z = -rbu_pkg::QUARTER_TURN;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			data_s2 <= rot;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

@@ rtl/core/rbu_cell.sv @@
// ----------------------------------------------------------------------------
// rbu_cell
// One vectoring CORDIC micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module rbu_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [rbu_pkg::IDX_W-1:0]     idx,
	input  logic                          in_valid,
	input  rbu_pkg::cordic_t              in_data,
	output logic                          out_valid,
	output rbu_pkg::cordic_t              out_data
);

	logic signed [rbu_pkg::DATA_W-1:0] x, y, xs, ys;
	logic [rbu_pkg::Z_W-1:0]           at;
	rbu_pkg::cordic_t                  nxt, data_q;
	logic                              valid_q;

	always_comb begin
		x   = $signed(in_data.x);
		y   = $signed(in_data.y);
		xs  = x >>> idx;
		ys  = y >>> idx;
		at  = rbu_pkg::atan_turn(idx);
		nxt = in_data;
		// indexes past the table leave the vector alone
		if (idx < rbu_pkg::IDX_W'(rbu_pkg::TABLE_LEN)) begin
			if (y[rbu_pkg::DATA_W-1]) begin
				nxt.x = x - ys;
				nxt.y = y + xs;
				nxt.z = in_data.z - at;
			end else begin
				nxt.x = x + ys;
				nxt.y = y - xs;
				nxt.z = in_data.z + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

@@ rtl/core/rbu_back.sv @@
// ----------------------------------------------------------------------------
// rbu_back
// Round the accumulated direction, subtract the heading, hold the result beat.
// ----------------------------------------------------------------------------
module rbu_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  rbu_pkg::cordic_t                  in_data,
	output logic                              out_valid,
	output logic signed [rbu_pkg::ANG_W-1:0]  bearing,
	output logic                              coincident
);

	localparam logic [rbu_pkg::Z_W-1:0] HALF_CODE = rbu_pkg::Z_W'(1) << (31 - rbu_pkg::ANG_W);

	logic [rbu_pkg::Z_W-1:0]   zr;
	logic [rbu_pkg::ANG_W-1:0] angle;
	logic [rbu_pkg::ANG_W-1:0] bearing_q;
	logic                      coincident_q, valid_q;

	always_comb begin
		zr    = in_data.z + HALF_CODE;
		angle = in_data.same ? '0 : zr[rbu_pkg::Z_W-1 -: rbu_pkg::ANG_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			bearing_q    <= angle - in_data.heading;
			coincident_q <= in_data.same;
		end
	end

	assign out_valid  = valid_q;
	assign bearing    = $signed(bearing_q);
	assign coincident = coincident_q;

endmodule

@@ rtl/core/relative_bearing_unit.sv @@
// ----------------------------------------------------------------------------
// relative_bearing_unit
// Relative bearing from a focal robot to one neighbor. Each input beat takes
// the focal position and heading and the neighbor position; each output beat
// gives atan2(dy, dx) minus the heading as a 16-bit binary angle (a full turn
// is 65536 codes, an exact half turn reads as the most negative code) and a
// coincident flag, set when both positions match, in which case the direction
// is taken as zero. The block takes one beat every clock cycle while the
// output is not stalled and returns results in order through two front
// stages (differences, half-plane fold), a chain of 16 CORDIC cells that
// each do one micro-rotation, and one output register.
// A stall on the output holds the whole chain, so in_stall follows out_stall
// only while a result waits at the output.
// ----------------------------------------------------------------------------
module relative_bearing_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [rbu_pkg::POS_W-1:0]  focal_x,
	input  logic signed [rbu_pkg::POS_W-1:0]  focal_y,
	input  logic signed [rbu_pkg::ANG_W-1:0]  focal_heading,
	input  logic signed [rbu_pkg::POS_W-1:0]  neighbor_x,
	input  logic signed [rbu_pkg::POS_W-1:0]  neighbor_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [rbu_pkg::ANG_W-1:0]  bearing,
	output logic                              coincident
);

	// Advance every stage together unless a finished beat is held at the output.
	logic advance;

	// Chain taps: tap 0 is the front output, tap STEPS feeds the output stage.
	logic             tap_valid [rbu_pkg::STEPS+1];
	rbu_pkg::cordic_t tap_data  [rbu_pkg::STEPS+1];

	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;

	rbu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.in_valid      (in_valid),
		.focal_x       (focal_x),
		.focal_y       (focal_y),
		.focal_heading (focal_heading),
		.neighbor_x    (neighbor_x),
		.neighbor_y    (neighbor_y),
		.out_valid     (tap_valid[0]),
		.out_data      (tap_data[0])
	);

	// One cell per micro-rotation; each cell knows its own shift and table entry.
	for (genvar i = 0; i < rbu_pkg::STEPS; i++) begin : g_cell
		rbu_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (advance),
			.idx       (rbu_pkg::IDX_W'(i)),
			.in_valid  (tap_valid[i]),
			.in_data   (tap_data[i]),
			.out_valid (tap_valid[i+1]),
			.out_data  (tap_data[i+1])
		);
	end

	// Round to output codes, subtract the heading, hold the beat until taken.
	rbu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.in_valid   (tap_valid[rbu_pkg::STEPS]),
		.in_data    (tap_data[rbu_pkg::STEPS]),
		.out_valid  (out_valid),
		.bearing    (bearing),
		.coincident (coincident)
	);

endmodule

@@ rtl/core/rbu_checker.sv @@
// ----------------------------------------------------------------------------
// rbu_checker
// Port-level checks: hold under stall, fixed-latency ordering, coincidence.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbu_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic signed [rbu_pkg::POS_W-1:0]  focal_x,
	input  logic signed [rbu_pkg::POS_W-1:0]  focal_y,
	input  logic signed [rbu_pkg::ANG_W-1:0]  focal_heading,
	input  logic signed [rbu_pkg::POS_W-1:0]  neighbor_x,
	input  logic signed [rbu_pkg::POS_W-1:0]  neighbor_y,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [rbu_pkg::ANG_W-1:0]  bearing,
	input  logic                              coincident
);

	localparam int LAT = rbu_pkg::LATENCY;

	// Shadow line: shifts whenever the block does not stall its input.
	logic                      vld_q  [LAT];
	logic                      same_q [LAT];
	logic [rbu_pkg::ANG_W-1:0] hd_q   [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (!in_stall) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < LAT; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			same_q[0] <= (neighbor_x == focal_x) && (neighbor_y == focal_y);
			hd_q[0]   <= focal_heading;
			for (int k = 1; k < LAT; k++) begin
				same_q[k] <= same_q[k-1];
				hd_q[k]   <= hd_q[k-1];
			end
		end
	end

	`RBU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`RBU_ASSERT_SAME(a_latency, clk, arst_n, 1'b1, out_valid == vld_q[LAT-1])
	`RBU_ASSERT_SAME(a_coincident, clk, arst_n, out_valid, coincident == same_q[LAT-1])
	`RBU_ASSERT_SAME(a_coincident_bearing, clk, arst_n, out_valid && coincident, $unsigned(bearing) == (rbu_pkg::ANG_W'(0) - hd_q[LAT-1]))

endmodule

bind relative_bearing_unit rbu_checker u_rbu_checker (.*);
